>>> sv/tdpb_pkg.sv
// Shared constants, types and the write-port bundle for the tail-drop packet buffer.
package tdpb_pkg;

   localparam int DEPTH      = 64;
   localparam int TIME_WIDTH = 40;

   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W   = $clog2(DEPTH + 1);
   localparam int CFG_W   = 7;
   localparam int ARR_W   = 32;
   localparam int PT_W    = 16;
   localparam int OUT_W   = 40;
   localparam int START_W = (TIME_WIDTH > ARR_W) ? TIME_WIDTH : ARR_W;
   localparam int CMP_W   = (OCC_W > CFG_W) ? OCC_W : CFG_W;

   localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(64);
   localparam logic [TIME_WIDTH-1:0] TIME_MAX  = {TIME_WIDTH{1'b1}};
   localparam logic [ADDR_W-1:0]     ADDR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [OCC_W-1:0]      OCC_FULL  = OCC_W'(DEPTH);

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [ADDR_W-1:0]     addr_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      time_type data;
   } ram_wr_type;

   function automatic addr_type addr_next(input addr_type a);
      return (a == ADDR_LAST) ? '0 : addr_type'(a + 1'b1);
   endfunction

endpackage

>>> sv/tdpb_ram.sv
// Finish-time storage: one write port, one registered read port with write-through.
module tdpb_ram (
   input  logic                 clock,
   input  tdpb_pkg::ram_wr_type wr,
   input  tdpb_pkg::addr_type   rd_addr,
   output tdpb_pkg::time_type   rd_data
);
   import tdpb_pkg::*;

   time_type mem [DEPTH];
   time_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tail_drop_packet_buffer.sv
// Top level: tail-drop packet buffer sequencer, FIFO pointers and result register.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_arrival_time[31:0], req_process_time[15:0]
//  rsp      out        rsp_valid/rsp_stall   rsp_dropped, rsp_start_time[39:0]
//  csr      in         csr_wr_en             csr_wr_data[6:0] (buffer_size)
//
// An item is accepted in IDLE, then in CHECK removes expired head entries one by one, each
// removal a compare of the head against the registered read of the finish-time RAM.
// The block is stalled on req from the accepting transfer until its result is registered.
// A result waits in the output register; the next item may be accepted meanwhile but
// holds its decision until that register frees. Reset is synchronous and empties the
// queue at once; buffer_size returns to 64.
module tail_drop_packet_buffer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [tdpb_pkg::ARR_W-1:0] req_arrival_time,
   input  logic [tdpb_pkg::PT_W-1:0]  req_process_time,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_dropped,
   output logic [tdpb_pkg::OUT_W-1:0] rsp_start_time,
   input  logic                      csr_wr_en,
   input  logic [tdpb_pkg::CFG_W-1:0] csr_wr_data
);
   import tdpb_pkg::*;

   typedef enum logic {ST_IDLE, ST_CHECK} state_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  size_ff;
   addr_type          head_ff, head_in;
   addr_type          tail_ff, tail_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   time_type          last_ff, last_in;
   logic [ARR_W-1:0]  arr_ff;
   logic [PT_W-1:0]   pt_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_dropped_ff, rsp_dropped_in;
   logic [OUT_W-1:0]  rsp_start_ff, rsp_start_in;

   ram_wr_type        wr;
   time_type          head_data;
   logic              rsp_free, expired, full;
   logic [START_W-1:0] start;
   logic [START_W:0]  sum;
   time_type          finish;

   tdpb_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (head_in),
      .rd_data (head_data)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign expired  = (occ_ff != '0) &&
                     (START_W'(head_data) <= START_W'(arr_ff));
   assign full     = (CMP_W'(occ_ff) >= CMP_W'(size_ff)) || (occ_ff == OCC_FULL);
   assign start    = (occ_ff == '0) ? START_W'(arr_ff) : START_W'(last_ff);
   assign sum      = (START_W + 1)'(start) + (START_W + 1)'(pt_ff);
   assign finish   = (sum > (START_W + 1)'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(sum);

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      occ_in         = occ_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_dropped_in = rsp_dropped_ff;
      rsp_start_in   = rsp_start_ff;
      wr.en          = 1'b0;
      wr.addr        = tail_ff;
      wr.data        = finish;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (expired) begin
               head_in = addr_next(head_ff);
               occ_in  = occ_ff - 1'b1;
            end else if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (full) begin
                  rsp_dropped_in = 1'b1;
                  rsp_start_in   = '0;
               end else begin
                  rsp_dropped_in = 1'b0;
                  rsp_start_in   = OUT_W'(start);
                  wr.en          = 1'b1;
                  last_in        = finish;
                  tail_in        = addr_next(tail_ff);
                  occ_in         = occ_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= CFG_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
      end
      last_ff        <= last_in;
      rsp_dropped_ff <= rsp_dropped_in;
      rsp_start_ff   <= rsp_start_in;
      if (state_ff == ST_IDLE && req_valid) begin
         arr_ff <= req_arrival_time;
         pt_ff  <= req_process_time;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dropped    = rsp_dropped_ff;
   assign rsp_start_time = rsp_start_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("occupancy above depth");

   a_ptr_occ: assert property (@(posedge clock) disable iff (reset)
      (int'(tail_ff) == int'(head_ff) + int'(occ_ff)) ||
      (int'(tail_ff) + DEPTH == int'(head_ff) + int'(occ_ff)))
      else $error("pointers disagree with occupancy");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dropped_ff |-> rsp_start_ff == '0)
      else $error("dropped packet with nonzero start time");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (occ_ff != OCC_FULL) && !expired)
      else $error("push into full queue or before head removal done");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |=> $past(occ_ff) == occ_ff)
      else $error("occupancy changed while idle");

endmodule

>>> verif/tail_drop_packet_buffer_checker.sv
// Checker for the tail-drop packet buffer: mirrors the finish-time queue and compares results.
module tail_drop_packet_buffer_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [tdpb_pkg::ARR_W-1:0] req_arrival_time,
   input  logic [tdpb_pkg::PT_W-1:0]  req_process_time,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_dropped,
   input  logic [tdpb_pkg::OUT_W-1:0] rsp_start_time,
   input  logic                       csr_wr_en,
   input  logic [tdpb_pkg::CFG_W-1:0] csr_wr_data,
   output int                         errors,
   output int                         pending,
   output int                         drops,
   output int                         peak_fill
);
   timeunit 1ns;
   timeprecision 1ps;
   import tdpb_pkg::*;

   typedef struct packed {
      logic             dropped;
      logic [OUT_W-1:0] start_at;
   } outcome_type;

   outcome_type      outcome_q[$];
   outcome_type      want;
   time_type         finish_ring [DEPTH];
   addr_type         oldest_slot;
   addr_type         next_slot;
   int               fill;
   logic [CFG_W-1:0] buffer_size;

   // Retire expired head entries, then drop or queue the packet behind the newest finish.
   function automatic outcome_type schedule_packet(input logic [ARR_W-1:0] arrival,
                                                   input logic [PT_W-1:0]  ptime);
      outcome_type           res;
      int                    cap;
      addr_type              newest_slot;
      time_type              start;
      logic [TIME_WIDTH:0]   sum;
      while (fill > 0 && finish_ring[oldest_slot] <= TIME_WIDTH'(arrival)) begin
         oldest_slot = (oldest_slot == ADDR_LAST) ? '0 : addr_type'(oldest_slot + 1'b1);
         fill--;
      end
      cap = (int'(buffer_size) > DEPTH) ? DEPTH : int'(buffer_size);
      if (fill >= cap) begin
         res.dropped  = 1'b1;
         res.start_at = '0;
         drops++;
      end else begin
         newest_slot = (next_slot == '0) ? ADDR_LAST : addr_type'(next_slot - 1'b1);
         start = (fill == 0) ? TIME_WIDTH'(arrival) : finish_ring[newest_slot];
         sum = {1'b0, start} + (TIME_WIDTH + 1)'(ptime);
         finish_ring[next_slot] = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
         next_slot = (next_slot == ADDR_LAST) ? '0 : addr_type'(next_slot + 1'b1);
         fill++;
         if (fill > peak_fill) peak_fill = fill;
         res.dropped  = 1'b0;
         res.start_at = OUT_W'(start);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         outcome_q.delete();
         fill        = 0;
         oldest_slot = '0;
         next_slot   = '0;
         buffer_size = CFG_RESET;
         errors      = 0;
         drops       = 0;
         peak_fill   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("rsp transfer with no packet outstanding: dropped %0b rsp_start_time %0h",
                      rsp_dropped, rsp_start_time);
               errors++;
            end else begin
               want = outcome_q[0];
               outcome_q.delete(0);
               if (rsp_dropped !== want.dropped) begin
                  $error("dropped: expected %0b, actual %0b", want.dropped, rsp_dropped);
                  errors++;
               end
               if (rsp_start_time !== want.start_at) begin
                  $error("rsp_start_time: expected %0h, actual %0h", want.start_at,
                         rsp_start_time);
                  errors++;
               end
            end
         end
         if (csr_wr_en) buffer_size = csr_wr_data;
         if (req_valid && !req_stall)
            outcome_q.insert(outcome_q.size(),
                             schedule_packet(req_arrival_time, req_process_time));
      end
      pending = outcome_q.size();
   end

endmodule

>>> verif/tail_drop_packet_buffer_tb.sv
// Testbench top for the tail-drop packet buffer: packet traffic, stall patterns and verdict.
module tail_drop_packet_buffer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tdpb_pkg::*;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [ARR_W-1:0]  req_arrival_time;
   logic [PT_W-1:0]   req_process_time;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_dropped;
   logic [OUT_W-1:0]  rsp_start_time;
   logic              csr_wr_en;
   logic [CFG_W-1:0]  csr_wr_data;

   int                errors;
   int                pending;
   int                drops;
   int                peak_fill;

   bit                no_gaps       = 1'b0;
   logic [ARR_W-1:0]  arrival_now   = '0;
   int                packets_sent  = 0;
   int                settings_used = 0;

   always #5 clock = ~clock;

   tail_drop_packet_buffer dut (.*);

   tail_drop_packet_buffer_checker queue_check (.*);

   function automatic int pause_cycles();
      return no_gaps ? 0 : int'($urandom_range(0, 5));
   endfunction

   task automatic send_packet(input logic [ARR_W-1:0] arrival, input logic [PT_W-1:0] ptime);
      int idle;
      idle = pause_cycles();
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_arrival_time <= arrival;
      req_process_time <= ptime;
      do @(posedge clock); while (!(req_valid && !req_stall));
      packets_sent++;
   endtask

   // Hold off the sender until every outstanding result is back and the block is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CFG_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic run_traffic(input logic [CFG_W-1:0] cap, input int count,
                              input int unsigned pt_cap, input int unsigned gap_cap);
      logic [ARR_W-1:0] arrival;
      int unsigned      back;
      int               roll;
      write_capacity(cap);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (count) begin
         roll = $urandom_range(0, 31);
         if (roll == 0) begin
            // late packet, behind the running arrival time
            back    = $urandom_range(0, 4 * pt_cap);
            arrival = (back > arrival_now) ? '0 : arrival_now - back;
         end else begin
            if (roll == 1 && gap_cap != 0) arrival_now += 70 * pt_cap;
            else if (roll == 2) settle();
            else arrival_now += $urandom_range(0, gap_cap);
            arrival = arrival_now;
         end
         send_packet(arrival, PT_W'($urandom_range(0, pt_cap)));
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      int hold;
      forever begin
         hold = pause_cycles();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            while (hold != 0) begin
               @(posedge clock);
               if (rsp_valid) hold--;
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_arrival_time <= '0;
      req_process_time <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: zero-length packets, expiry at equal time, late arrival
      send_packet(32'd0, 16'd0);
      send_packet(32'd0, 16'hFFFF);
      send_packet(32'd10, 16'd5);
      send_packet(32'd5, 16'd1);
      send_packet(32'd65540, 16'd3);

      // zero capacity still retires expired entries
      write_capacity(7'd0);
      send_packet(32'd100000, 16'd7);
      send_packet(32'd100000, 16'hFFFF);

      write_capacity(7'd1);
      send_packet(32'd200000, 16'd10);
      send_packet(32'd200005, 16'd1);
      send_packet(32'd200010, 16'd2);

      write_capacity(7'd2);
      send_packet(32'd200011, 16'd100);
      send_packet(32'd200011, 16'd100);
      send_packet(32'd200112, 16'd1);

      // capacity above depth saturates
      write_capacity(7'h7F);
      send_packet(32'hFFFF_FFFF, 16'd0);
      send_packet(32'hFFFF_FFFF, 16'd0);

      // flush the queue with a latest-possible arrival
      write_capacity(7'd0);
      send_packet(32'hFFFF_FFFF, 16'h1234);

      arrival_now = 32'd300000;
      run_traffic(7'd127, 80, 255, 0);
      run_traffic(7'd64, 50, 4095, 4000);
      run_traffic(7'd1, 40, 255, 300);
      run_traffic(7'd0, 15, 255, 255);
      run_traffic(7'd2, 40, 15, 20);
      run_traffic(7'd5, 40, 4095, 3000);
      run_traffic(7'd64, 60, 65535, 60000);
      run_traffic(7'd17, 50, 255, 200);
      run_traffic(7'd8, 45, 15, 10);
      run_traffic(7'd100, 60, 4095, 5000);
      run_traffic(7'd3, 40, 65535, 90000);
      run_traffic(7'd33, 40, 255, 250);

      // start times past 32 bits
      write_capacity(7'd64);
      send_packet(32'hFFFF_FFFF, 16'hFFFF);
      send_packet(32'hFFFF_FFFF, 16'hFFFF);
      send_packet(32'd0, 16'd0);

      settle();
      repeat (70) @(posedge clock);
      $display("Covered %0d packets over %0d buffer_size writes; %0d dropped, queue peaked at %0d.",
               packets_sent, settings_used, drops, peak_fill);
      if (errors == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5ms;
      $error("timed out with %0d results outstanding", pending);
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
sv/tdpb_pkg.sv
sv/tdpb_ram.sv
sv/tail_drop_packet_buffer.sv
verif/tail_drop_packet_buffer_checker.sv
verif/tail_drop_packet_buffer_tb.sv
